FILE: design/first_fit_vm_node_allocator_unit_assert.svh
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_VM_NODE_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_VM_NODE_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFVA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFVA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ffva_pkg.sv
// Shared widths, reset values, register indexes and types for the allocator.
package ffva_pkg;

  localparam int PROC_W    = 8;
  localparam int MEM_W     = 16;
  localparam int STOR_W    = 20;
  localparam int IDX_OUT_W = 6;

  localparam int NODE_COUNT_DEF = 8;

  localparam logic [PROC_W-1:0] RST_CAP_PROC = PROC_W'(24);
  localparam logic [MEM_W-1:0]  RST_CAP_MEM  = MEM_W'(128);
  localparam logic [STOR_W-1:0] RST_CAP_STOR = STOR_W'(3200);

  // APB register map: register i at byte address 4*i
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_PROC_CAP = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MEM_CAP  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOR_CAP = 2'd2;

  // input action codes
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RESTORE = 1'b1;

  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic [MEM_W-1:0]  mem;
    logic [STOR_W-1:0] stor;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic restore;
  } pool_cmd_t;

endpackage

FILE: design/first_fit_vm_node_allocator_unit.sv
// Top level of the first-fit node allocator: config registers, sequencer, pool.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    action, need_proc, need_mem, need_storage
//   out      source     out_valid / out_stall  granted, node_index, left_proc/mem/storage
//   cfg      APB slave  psel/penable/pready    paddr, pwdata, prdata (capacity registers)
//
// An allocate transaction scans the pool first-fit after acceptance, with one pool read
// per node until a node fits or the last node misses; the charged node is written back in
// the cycle its fit is found. A restore goes from acceptance straight to the result state.
// Reset (rst_n low, synchronous) clears the pool to the reset capacities via valid bits;
// no clearing pass is needed. A stalled result holds; the next transaction is accepted
// as soon as the previous result sits in the output register.
module first_fit_vm_node_allocator_unit #(
  parameter int NODE_COUNT = ffva_pkg::NODE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [ffva_pkg::PROC_W-1:0]    in_need_proc,
  input  logic [ffva_pkg::MEM_W-1:0]     in_need_mem,
  input  logic [ffva_pkg::STOR_W-1:0]    in_need_storage,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_granted,
  output logic [ffva_pkg::IDX_OUT_W-1:0] out_node_index,
  output logic [ffva_pkg::PROC_W-1:0]    out_left_proc,
  output logic [ffva_pkg::MEM_W-1:0]     out_left_mem,
  output logic [ffva_pkg::STOR_W-1:0]    out_left_storage,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffva_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ffva_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ffva_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ffva_pkg::*;

  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic [PROC_W-1:0]    cap_proc_r;
  logic [MEM_W-1:0]     cap_mem_r;
  logic [STOR_W-1:0]    cap_stor_r;
  logic                 apb_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  pool_cmd_t            pool_cmd;
  logic [IDX_W-1:0]     pool_addr;
  entry_t               pool_wr_data;
  entry_t               pool_rd_data;
  entry_t               cap_entry;

  // --- capacity registers: only take effect at the next restore ---
  assign pready  = 1'b1;
  assign apb_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_proc_r <= RST_CAP_PROC;
      cap_mem_r  <= RST_CAP_MEM;
      cap_stor_r <= RST_CAP_STOR;
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_PROC_CAP: cap_proc_r <= pwdata[PROC_W-1:0];
        REG_MEM_CAP:  cap_mem_r  <= pwdata[MEM_W-1:0];
        REG_STOR_CAP: cap_stor_r <= pwdata[STOR_W-1:0];
        default: ;   // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROC_CAP: prdata = APB_DATA_W'(cap_proc_r);
      REG_MEM_CAP:  prdata = APB_DATA_W'(cap_mem_r);
      REG_STOR_CAP: prdata = APB_DATA_W'(cap_stor_r);
      default:      prdata = '0;
    endcase
  end

  assign cap_entry = '{proc: cap_proc_r, mem: cap_mem_r, stor: cap_stor_r};

  // --- scan sequencer and result register ---
  ffva_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_need_proc     (in_need_proc),
    .in_need_mem      (in_need_mem),
    .in_need_storage  (in_need_storage),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_node_index   (out_node_index),
    .out_left_proc    (out_left_proc),
    .out_left_mem     (out_left_mem),
    .out_left_storage (out_left_storage),
    .pool_cmd         (pool_cmd),
    .pool_addr        (pool_addr),
    .pool_wr_data     (pool_wr_data),
    .pool_rd_data     (pool_rd_data)
  );

  // --- node pool memory (registered read) ---
  ffva_pool #(
    .NODE_COUNT (NODE_COUNT),
    .IDX_W      (IDX_W)
  ) u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pool_cmd),
    .addr      (pool_addr),
    .wr_data   (pool_wr_data),
    .fill_data (cap_entry),
    .rd_data   (pool_rd_data)
  );

endmodule

FILE: design/ffva_pool.sv
// Node pool memory: one entry per node, valid bits, restore fill value.
module ffva_pool #(
  parameter int NODE_COUNT = ffva_pkg::NODE_COUNT_DEF,
  parameter int IDX_W      = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffva_pkg::pool_cmd_t cmd,
  input  logic [IDX_W-1:0]   addr,
  input  ffva_pkg::entry_t   wr_data,
  input  ffva_pkg::entry_t   fill_data,
  output ffva_pkg::entry_t   rd_data
);
  import ffva_pkg::*;

  entry_t                  pool_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0]   valid_r;
  entry_t                  fill_r;
  entry_t                  rd_q_r;
  logic                    rd_hit_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      pool_mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= pool_mem[addr];
    end
  end

  // written-since-restore flags and the value that unwritten entries read as
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
      fill_r   <= '{proc: RST_CAP_PROC, mem: RST_CAP_MEM, stor: RST_CAP_STOR};
    end else begin
      if (cmd.restore) begin
        valid_r <= '0;
        fill_r  <= fill_data;
      end else if (cmd.wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_hit_r <= valid_r[addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : fill_r;

endmodule

FILE: design/ffva_ctrl.sv
// Request sequencer: first-fit scan over the pool, write-back, result register.
module ffva_ctrl #(
  parameter int NODE_COUNT = ffva_pkg::NODE_COUNT_DEF,
  parameter int IDX_W      = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [ffva_pkg::PROC_W-1:0]  in_need_proc,
  input  logic [ffva_pkg::MEM_W-1:0]   in_need_mem,
  input  logic [ffva_pkg::STOR_W-1:0]  in_need_storage,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_granted,
  output logic [ffva_pkg::IDX_OUT_W-1:0] out_node_index,
  output logic [ffva_pkg::PROC_W-1:0]  out_left_proc,
  output logic [ffva_pkg::MEM_W-1:0]   out_left_mem,
  output logic [ffva_pkg::STOR_W-1:0]  out_left_storage,
  output ffva_pkg::pool_cmd_t          pool_cmd,
  output logic [IDX_W-1:0]             pool_addr,
  output ffva_pkg::entry_t             pool_wr_data,
  input  ffva_pkg::entry_t             pool_rd_data
);
  import ffva_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  entry_t               need_r, need_nxt;
  logic                 res_grant_r, res_grant_nxt;
  logic [IDX_OUT_W-1:0] res_idx_r, res_idx_nxt;
  entry_t               res_left_r, res_left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 out_granted_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  entry_t               out_left_r;
  logic                 fit;
  entry_t               charged;

  assign fit = (pool_rd_data.proc >= need_r.proc) && (pool_rd_data.mem >= need_r.mem) &&
               (pool_rd_data.stor >= need_r.stor);

  assign charged.proc = pool_rd_data.proc - need_r.proc;
  assign charged.mem  = pool_rd_data.mem - need_r.mem;
  assign charged.stor = pool_rd_data.stor - need_r.stor;

  assign in_stall     = (state_r != ST_IDLE);
  assign pool_wr_data = charged;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    need_nxt      = need_r;
    res_grant_nxt = res_grant_r;
    res_idx_nxt   = res_idx_r;
    res_left_nxt  = res_left_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_load      = 1'b0;
    pool_cmd      = '0;
    pool_addr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          need_nxt      = '{proc: in_need_proc, mem: in_need_mem, stor: in_need_storage};
          res_grant_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_left_nxt  = '0;
          if (in_action == ACT_RESTORE) begin
            pool_cmd.restore = 1'b1;
            state_nxt        = ST_FIN;
          end else begin
            pool_cmd.rd_en = 1'b1;
            idx_nxt        = '0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read data for idx_r is present; on a miss short of the last entry the next read goes out
        if (fit) begin
          pool_cmd.wr_en = 1'b1;
          pool_addr      = idx_r;
          res_grant_nxt  = 1'b1;
          res_idx_nxt    = IDX_OUT_W'(idx_r);
          res_left_nxt   = charged;
          state_nxt      = ST_FIN;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          pool_cmd.rd_en = 1'b1;
          pool_addr      = idx_r + 1'b1;
          idx_nxt        = idx_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    need_r      <= need_nxt;
    res_grant_r <= res_grant_nxt;
    res_idx_r   <= res_idx_nxt;
    res_left_r  <= res_left_nxt;
    if (out_load) begin
      out_granted_r <= res_grant_r;
      out_idx_r     <= res_idx_r;
      out_left_r    <= res_left_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_node_index   = out_idx_r;
  assign out_left_proc    = out_left_r.proc;
  assign out_left_mem     = out_left_r.mem;
  assign out_left_storage = out_left_r.stor;

endmodule

FILE: design/ffva_checker.sv
// Port-level checker for the allocator, bound to the top level.
`include "first_fit_vm_node_allocator_unit_assert.svh"

module ffva_checker #(
  parameter int NODE_COUNT = ffva_pkg::NODE_COUNT_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_granted,
  input logic [ffva_pkg::IDX_OUT_W-1:0]  out_node_index,
  input logic [ffva_pkg::PROC_W-1:0]     out_left_proc,
  input logic [ffva_pkg::MEM_W-1:0]      out_left_mem,
  input logic [ffva_pkg::STOR_W-1:0]     out_left_storage
);
  import ffva_pkg::*;

  `FFVA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_granted) && $stable(out_node_index) && $stable(out_left_storage), "stalled result changed")
  `FFVA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_granted, out_node_index == 0 && out_left_proc == 0 && out_left_mem == 0 && out_left_storage == 0, "ungranted result not zero")
  `FFVA_ASSERT_IMP(a_idx_range, clk, rst_n, out_valid && out_granted, out_node_index < NODE_COUNT, "granted node index out of range")
  `FFVA_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second transaction taken during work")

endmodule

bind first_fit_vm_node_allocator_unit ffva_checker #(.NODE_COUNT(NODE_COUNT)) u_ffva_checker (.*);
